>>> src/dclsr_pkg.sv
// Shared types and constants for the dual-chain LED shift refresher.
// No dependencies; every other file in src imports this package.
package dclsr_pkg;

  localparam int WORD_BITS = 16;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int LEN_W     = 4;
  localparam int IVL_W     = 8;
  localparam int IDX_W     = 3;
  localparam int REG_W     = 2;
  localparam int CFG_DW    = 8;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_MS_TICK   = 2'd1,
    OP_SLOT_TICK = 2'd2
  } op_t;

  localparam logic [REG_W-1:0] REG_INTERVAL   = 2'd0;
  localparam logic [REG_W-1:0] REG_FIRST_LEN  = 2'd1;
  localparam logic [REG_W-1:0] REG_SECOND_LEN = 2'd2;

  localparam logic [IVL_W-1:0] INTERVAL_RESET   = 8'd25;
  localparam logic [LEN_W-1:0] FIRST_LEN_RESET  = 4'd6;
  localparam logic [LEN_W-1:0] SECOND_LEN_RESET = 4'd8;
  localparam logic [IVL_W-1:0] COUNT_MAX        = 8'd255;

  typedef struct packed {
    logic [1:0]           operation;
    logic                 chain_select;
    logic [IDX_W-1:0]     word_index;
    logic [WORD_BITS-1:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic first_data_bit;
    logic second_data_bit;
    logic shift_clock_pulse;
    logic latch_pulse;
    logic frame_busy;
  } out_item_t;

  typedef struct packed {
    logic [IVL_W-1:0] refresh_interval;
    logic [LEN_W-1:0] first_chain_length;
    logic [LEN_W-1:0] second_chain_length;
  } cfg_regs_t;

endpackage

>>> src/dclsr_if.sv
// Handshake channels of the dual-chain LED shift refresher: items, results, register writes.
// Depends on dclsr_pkg for field widths.
interface dclsr_item_if import dclsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic                 chain_select;
  logic [IDX_W-1:0]     word_index;
  logic [WORD_BITS-1:0] word_value;

  modport source (output valid, operation, chain_select, word_index, word_value,
                  input ready);
  modport sink (input valid, operation, chain_select, word_index, word_value,
                output ready);
endinterface

interface dclsr_result_if;
  logic valid;
  logic ready;
  logic first_data_bit;
  logic second_data_bit;
  logic shift_clock_pulse;
  logic latch_pulse;
  logic frame_busy;

  modport source (output valid, first_data_bit, second_data_bit, shift_clock_pulse,
                  latch_pulse, frame_busy, input ready);
  modport sink (input valid, first_data_bit, second_data_bit, shift_clock_pulse,
                latch_pulse, frame_busy, output ready);
endinterface

interface dclsr_cfg_if import dclsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REG_W-1:0]  index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/dual_chain_led_shift_refresher_unit.sv
// Top level of the dual-chain LED shift refresher: input and result registers, config registers.
// Depends on dclsr_pkg, dclsr_if, dclsr_word_buf and dclsr_serializer.
//
//   Channel   Direction  Beat carries
//   item      in         operation, chain_select, word_index, word_value
//   result    out        first/second_data_bit, shift_clock_pulse, latch_pulse, frame_busy
//   cfg       in         register index and data (always ready)
//
// Each item passes through two registers from its input beat to its result beat: the input
// register, then the result register. A new item is taken every cycle unless the result stalls.
// The input register only moves on when the result register is empty or being drained,
// so a stalled result holds the item behind it.
// Synchronous reset clears the buffers and arms one zero frame.
module dual_chain_led_shift_refresher_unit import dclsr_pkg::*; #(
  parameter int MAX_WORDS = 8
) (
  input  logic           clk,
  input  logic           rst,
  dclsr_item_if.sink     item,
  dclsr_result_if.source result,
  dclsr_cfg_if.sink      cfg
);

  localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic                 s1_valid;
  in_item_t             s1_item;
  logic                 out_valid;
  out_item_t            out_res;
  cfg_regs_t            regs;
  logic                 advance;
  out_item_t            res;
  logic [WIDX_W-1:0]    slot;
  logic [WORD_BITS-1:0] first_pick;
  logic [WORD_BITS-1:0] second_pick;
  logic                 wr_beat;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;
  assign cfg.ready  = 1'b1;
  assign wr_beat    = advance && (s1_item.operation == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_item.operation    <= item.operation;
      s1_item.chain_select <= item.chain_select;
      s1_item.word_index   <= item.word_index;
      s1_item.word_value   <= item.word_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.refresh_interval    <= INTERVAL_RESET;
      regs.first_chain_length  <= FIRST_LEN_RESET;
      regs.second_chain_length <= SECOND_LEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_INTERVAL:   regs.refresh_interval    <= cfg.data;
        REG_FIRST_LEN:  regs.first_chain_length  <= cfg.data[LEN_W-1:0];
        REG_SECOND_LEN: regs.second_chain_length <= cfg.data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dclsr_word_buf #(.MAX_WORDS(MAX_WORDS)) u_first_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_beat && !s1_item.chain_select),
    .wr_index (s1_item.word_index),
    .wr_value (s1_item.word_value),
    .length   (regs.first_chain_length),
    .slot     (slot),
    .word     (first_pick)
  );

  dclsr_word_buf #(.MAX_WORDS(MAX_WORDS)) u_second_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_beat && s1_item.chain_select),
    .wr_index (s1_item.word_index),
    .wr_value (s1_item.word_value),
    .length   (regs.second_chain_length),
    .slot     (slot),
    .word     (second_pick)
  );

  dclsr_serializer #(.MAX_WORDS(MAX_WORDS)) u_serializer (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (s1_item),
    .regs        (regs),
    .first_pick  (first_pick),
    .second_pick (second_pick),
    .slot        (slot),
    .res         (res)
  );

  assign result.valid             = out_valid;
  assign result.first_data_bit    = out_res.first_data_bit;
  assign result.second_data_bit   = out_res.second_data_bit;
  assign result.shift_clock_pulse = out_res.shift_clock_pulse;
  assign result.latch_pulse       = out_res.latch_pulse;
  assign result.frame_busy        = out_res.frame_busy;

endmodule

>>> src/dclsr_word_buf.sv
// Word buffer of one chain, with the front-padding word selection for a frame slot.
// Depends on dclsr_pkg.
module dclsr_word_buf import dclsr_pkg::*; #(
  parameter int MAX_WORDS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_index,
  input  logic [WORD_BITS-1:0] wr_value,
  input  logic [LEN_W-1:0]     length,
  input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] slot,
  output logic [WORD_BITS-1:0] word
);

  localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_WORDS + 1);
  localparam int CW     = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [WORD_BITS-1:0] words [MAX_WORDS];

  logic [CW-1:0]     len_ext;
  logic [CW-1:0]     depth;
  logic [CW-1:0]     used;
  logic [CW-1:0]     offset;
  logic [CW-1:0]     slot_ext;
  logic [CW-1:0]     k_ext;
  logic [WIDX_W-1:0] k;
  logic              wr_ok;

  assign wr_ok = CW'(wr_index) < CW'(MAX_WORDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        words[i] <= '0;
      end
    end else if (wr_en && wr_ok) begin
      words[WIDX_W'(wr_index)] <= wr_value;
    end
  end

  // A chain shorter than the frame sits at the back; the slots in front of it send zero.
  always_comb begin
    len_ext  = CW'(length);
    depth    = CW'(MAX_WORDS);
    used     = (len_ext > depth) ? depth : len_ext;
    offset   = depth - used;
    slot_ext = CW'(slot);
    k_ext    = slot_ext - offset;
    k        = WIDX_W'(k_ext);
    word     = (slot_ext >= offset) ? words[k] : '0;
  end

endmodule

>>> src/dclsr_serializer.sv
// Refresh counter, frame sequencer and the two output shift words.
// Depends on dclsr_pkg; the word buffers are read through first_pick and second_pick.
module dclsr_serializer import dclsr_pkg::*; #(
  parameter int MAX_WORDS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  in_item_t             item,
  input  cfg_regs_t            regs,
  input  logic [WORD_BITS-1:0] first_pick,
  input  logic [WORD_BITS-1:0] second_pick,
  output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] slot,
  output out_item_t            res
);

  localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [IVL_W-1:0]     refresh_count, refresh_count_next;
  logic                 frame_pending, frame_pending_next;
  logic                 frame_active, frame_active_next;
  logic [WIDX_W-1:0]    pos_word, pos_word_next;
  logic [BIT_W-1:0]     pos_bit, pos_bit_next;
  logic [WORD_BITS-1:0] first_shift, first_shift_next;
  logic [WORD_BITS-1:0] second_shift, second_shift_next;

  logic [IVL_W-1:0]     count_inc;
  logic [WIDX_W-1:0]    cur_word;
  logic [BIT_W-1:0]     cur_bit;
  logic                 last_slot;
  logic [WORD_BITS-1:0] first_src;
  logic [WORD_BITS-1:0] second_src;

  // A frame that is about to start runs from slot zero.
  assign cur_word  = frame_active ? pos_word : '0;
  assign cur_bit   = frame_active ? pos_bit : '0;
  assign slot      = cur_word;
  assign last_slot = (cur_word == WIDX_W'(MAX_WORDS - 1)) && (cur_bit == BIT_W'(WORD_BITS - 1));
  assign count_inc = (refresh_count < COUNT_MAX) ? refresh_count + 1'b1 : refresh_count;
  assign first_src  = (cur_bit == '0) ? first_pick : first_shift;
  assign second_src = (cur_bit == '0) ? second_pick : second_shift;

  always_comb begin
    refresh_count_next = refresh_count;
    frame_pending_next = frame_pending;
    frame_active_next  = frame_active;
    pos_word_next      = pos_word;
    pos_bit_next       = pos_bit;
    first_shift_next   = first_shift;
    second_shift_next  = second_shift;
    res                = '0;
    res.frame_busy     = frame_active;

    case (item.operation)
      OP_MS_TICK: begin
        refresh_count_next = count_inc;
        if (count_inc >= regs.refresh_interval) begin
          refresh_count_next = '0;
          frame_pending_next = 1'b1;
        end
      end
      OP_SLOT_TICK: begin
        if (frame_active || frame_pending) begin
          if (!frame_active) begin
            frame_pending_next = 1'b0;
          end
          res.first_data_bit    = first_src[WORD_BITS-1];
          res.second_data_bit   = second_src[WORD_BITS-1];
          res.shift_clock_pulse = 1'b1;
          res.frame_busy        = 1'b1;
          first_shift_next      = first_src << 1;
          second_shift_next     = second_src << 1;
          if (last_slot) begin
            res.latch_pulse   = 1'b1;
            frame_active_next = 1'b0;
            pos_word_next     = '0;
            pos_bit_next      = '0;
            first_shift_next  = '0;
            second_shift_next = '0;
          end else begin
            frame_active_next = 1'b1;
            pos_bit_next      = cur_bit + 1'b1;
            pos_word_next     = (cur_bit == BIT_W'(WORD_BITS - 1)) ? cur_word + 1'b1 : cur_word;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_count <= '0;
      frame_pending <= 1'b1;
      frame_active  <= 1'b0;
      pos_word      <= '0;
      pos_bit       <= '0;
      first_shift   <= '0;
      second_shift  <= '0;
    end else if (step) begin
      refresh_count <= refresh_count_next;
      frame_pending <= frame_pending_next;
      frame_active  <= frame_active_next;
      pos_word      <= pos_word_next;
      pos_bit       <= pos_bit_next;
      first_shift   <= first_shift_next;
      second_shift  <= second_shift_next;
    end
  end

  a_latch_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (step && res.latch_pulse) |=> !frame_active)
    else $error("frame still active after latch slot");

  a_mid_frame_stays: assert property (@(posedge clk) disable iff (rst)
    (step && res.shift_clock_pulse && !res.latch_pulse) |=> frame_active)
    else $error("frame dropped before its final slot");

  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    (step && item.operation == OP_MS_TICK) |=> (refresh_count != '0 || frame_pending))
    else $error("refresh counter cleared without a frame request");

  a_idle_shift_clear: assert property (@(posedge clk) disable iff (rst)
    !frame_active |-> (first_shift == '0 && second_shift == '0))
    else $error("shift words not clear while idle");

endmodule
